// File: rtl/mtt_pkg.sv
package mtt_pkg;

   // Fixed field widths of the item ports.
   localparam int KIND_W   = 3;
   localparam int HANDLE_W = 5;
   localparam int STATUS_W = 2;
   localparam int FIELD_W  = 32;

   // At most this many expiries are reported for one tick.
   localparam int MAX_RESULTS = 16;
   // The report counter holds 0 up to MAX_RESULTS.
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   // Command kinds.
   localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PAUSE   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNPAUSE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd5;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HANDLE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED   = 2'd2;

   // Which result the datapath loads into the output register on an emit.
   typedef enum logic [1:0] {
      RSEL_TICK_END = 2'd0,
      RSEL_SET_OK   = 2'd1,
      RSEL_SET_REJ  = 2'd2,
      RSEL_HANDLE   = 2'd3
   } rsel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     load;     // capture the accepted item
      logic     idx_clr;  // restart the slot scan
      logic     idx_inc;  // advance the slot scan
      logic     rd;       // read the slot RAMs at the scan index
      logic     sub;      // subtract the elapsed time
      logic     upd;      // write back, fire and reload or free
      logic     set_wr;   // load a new timer into the scan slot
      logic     hop;      // clear, pause or unpause the addressed slot
      logic     emit;     // load a final result into the output register
      rsel_type sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              idx_last;
      logic              slot_live;
      logic              slot_free;
      logic              rate_zero;
      logic              need_out;
      logic              out_free;
   } stat_type;

endpackage

// File: rtl/mtt_ram.sv
module mtt_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mtt_ctrl.sv
module mtt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mtt_pkg::stat_type stat,
   output mtt_pkg::cmd_type  cmd
);

   import mtt_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECODE = 9'b000000010,
      S_TSCAN  = 9'b000000100,
      S_TSUB   = 9'b000001000,
      S_TUPD   = 9'b000010000,
      S_TEND   = 9'b000100000,
      S_SSCAN  = 9'b001000000,
      S_SREJ   = 9'b010000000,
      S_HOP    = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      cmd.sel  = RSEL_TICK_END;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load    = 1'b1;
               cmd.idx_clr = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.kind)
               KIND_TICK: state_in = S_TSCAN;
               KIND_SET:  state_in = stat.rate_zero ? S_SREJ : S_SSCAN;
               default:   state_in = S_HOP;
            endcase
         end
         S_TSCAN: begin
            if (stat.slot_live) begin
               cmd.rd   = 1'b1;
               state_in = S_TSUB;
            end else if (stat.idx_last) begin
               state_in = S_TEND;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_TSUB: begin
            cmd.sub  = 1'b1;
            state_in = S_TUPD;
         end
         S_TUPD: begin
            // Hold while an earlier expiry still has to leave through a full output.
            if (!(stat.need_out && !stat.out_free)) begin
               cmd.upd = 1'b1;
               if (stat.idx_last) begin
                  state_in = S_TEND;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_TSCAN;
               end
            end
         end
         S_TEND: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = RSEL_TICK_END;
               state_in = S_IDLE;
            end
         end
         S_SSCAN: begin
            if (stat.slot_free) begin
               if (stat.out_free) begin
                  cmd.set_wr = 1'b1;
                  cmd.emit   = 1'b1;
                  cmd.sel    = RSEL_SET_OK;
                  state_in   = S_IDLE;
               end
            end else if (stat.idx_last) begin
               state_in = S_SREJ;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_SREJ: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.sel  = RSEL_SET_REJ;
               state_in = S_IDLE;
            end
         end
         S_HOP: begin
            if (stat.out_free) begin
               cmd.hop  = 1'b1;
               cmd.emit = 1'b1;
               cmd.sel  = RSEL_HANDLE;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// File: rtl/mtt_datapath.sv
module mtt_datapath #(
   parameter int NUM_TIMERS = 16,
   parameter int TIME_BITS  = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mtt_pkg::cmd_type               cmd,
   output mtt_pkg::stat_type              stat,
   input  logic [mtt_pkg::KIND_W-1:0]     req_kind,
   input  logic [mtt_pkg::HANDLE_W-1:0]   req_handle,
   input  logic [mtt_pkg::FIELD_W-1:0]    req_rate,
   input  logic                           req_repeat_req,
   input  logic [mtt_pkg::FIELD_W-1:0]    req_delta,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic [mtt_pkg::HANDLE_W-1:0]   rsp_result_handle,
   output logic                           rsp_fired,
   output logic [mtt_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_is_paused,
   output logic                           rsp_is_active,
   output logic                           rsp_last
);

   import mtt_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int REM_W = TIME_BITS + 2;
   localparam logic signed [REM_W:0]   FLOOR_WIDE = {2'b11, {(REM_W - 1){1'b0}}};
   localparam logic signed [REM_W-1:0] FLOOR      = {1'b1, {(REM_W - 1){1'b0}}};

   // Captured item.
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [HANDLE_W-1:0]  handle_ff, handle_in;
   logic [TIME_BITS-1:0] rate_ff, rate_in;
   logic                 rep_ff, rep_in;
   logic [TIME_BITS-1:0] delta_ff, delta_in;

   // Scan and slot flags.
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [NUM_TIMERS-1:0] used_ff, used_in;
   logic [NUM_TIMERS-1:0] paused_ff, paused_in;
   logic [NUM_TIMERS-1:0] loop_ff, loop_in;

   // Tick arithmetic and expiry reporting.
   logic signed [REM_W-1:0] r_ff, r_in;
   logic                    pend_ff, pend_in;
   logic [HANDLE_W-1:0]     pend_hnd_ff, pend_hnd_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] out_handle_ff, out_handle_in;
   logic                out_fired_ff, out_fired_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic                out_paused_ff, out_paused_in;
   logic                out_active_ff, out_active_in;
   logic                out_last_ff, out_last_in;

   logic [TIME_BITS+FIELD_W-1:0] rate_ext;
   logic [TIME_BITS+FIELD_W-1:0] delta_ext;
   logic [HANDLE_W-1:0]          h_m1;
   logic [IDX_W+HANDLE_W-1:0]    h_ext;
   logic [IDX_W-1:0]             hidx;
   logic                         h_ok;
   logic                         found;
   logic [IDX_W+HANDLE_W-1:0]    idx_p1;
   logic [HANDLE_W-1:0]          idx_hnd;
   logic [TIME_BITS-1:0]         per_rd;
   logic [REM_W-1:0]             rem_rd;
   logic signed [REM_W:0]        diff;
   logic signed [REM_W-1:0]      reload;
   logic signed [REM_W-1:0]      rem_upd;
   logic                         fire;
   logic                         report;
   logic                         need_out;
   logic                         out_load;
   logic                         rem_wr_en;
   logic [REM_W-1:0]             rem_wr_data;

   assign rate_ext  = {{TIME_BITS{1'b0}}, req_rate};
   assign delta_ext = {{TIME_BITS{1'b0}}, req_delta};

   // Handle decode: a handle is the slot number plus one.
   assign h_m1  = handle_ff - 5'd1;
   assign h_ext = {{IDX_W{1'b0}}, h_m1};
   assign hidx  = h_ext[IDX_W-1:0];
   assign h_ok  = (handle_ff != '0) && (32'(handle_ff) <= NUM_TIMERS);
   assign found = h_ok && used_ff[hidx];

   assign idx_p1  = {{HANDLE_W{1'b0}}, idx_ff} + (IDX_W + HANDLE_W)'(1);
   assign idx_hnd = idx_p1[HANDLE_W-1:0];

   mtt_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (NUM_TIMERS)
   ) u_period_ram (
      .clock   (clock),
      .wr_en   (cmd.set_wr),
      .wr_addr (idx_ff),
      .wr_data (rate_ff),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff),
      .rd_data (per_rd)
   );

   mtt_ram #(
      .WIDTH (REM_W),
      .DEPTH (NUM_TIMERS)
   ) u_remain_ram (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (idx_ff),
      .wr_data (rem_wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (idx_ff),
      .rd_data (rem_rd)
   );

   // Subtract with saturation at the floor of the signed count.
   always_comb begin
      diff = $signed({rem_rd[REM_W-1], rem_rd}) - $signed({3'b000, delta_ff});
      if (diff < FLOOR_WIDE) begin
         r_in = FLOOR;
      end else begin
         r_in = diff[REM_W-1:0];
      end
      if (!cmd.sub) begin
         r_in = r_ff;
      end
   end

   assign fire     = r_ff[REM_W-1] || (r_ff == '0);
   assign reload   = r_ff + $signed({2'b00, per_rd});
   assign rem_upd  = (fire && loop_ff[idx_ff]) ? reload : r_ff;
   assign report   = (cnt_ff < CNT_W'(MAX_RESULTS));
   assign need_out = fire && report && pend_ff;

   assign rem_wr_en   = cmd.set_wr || cmd.upd;
   assign rem_wr_data = cmd.set_wr ? {2'b00, rate_ff} : rem_upd;

   assign out_load = (cmd.upd && need_out) || cmd.emit;

   always_comb begin
      kind_in   = kind_ff;
      handle_in = handle_ff;
      rate_in   = rate_ff;
      rep_in    = rep_ff;
      delta_in  = delta_ff;
      if (cmd.load) begin
         kind_in   = req_kind;
         handle_in = req_handle;
         rate_in   = rate_ext[TIME_BITS-1:0];
         rep_in    = req_repeat_req;
         delta_in  = delta_ext[TIME_BITS-1:0];
      end

      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end

      used_in   = used_ff;
      paused_in = paused_ff;
      loop_in   = loop_ff;
      if (cmd.set_wr) begin
         used_in[idx_ff]   = 1'b1;
         paused_in[idx_ff] = 1'b0;
         loop_in[idx_ff]   = rep_ff;
      end
      if (cmd.upd && fire && !loop_ff[idx_ff]) begin
         used_in[idx_ff] = 1'b0;
      end
      if (cmd.hop && found) begin
         case (kind_ff)
            KIND_CLEAR:   used_in[hidx]   = 1'b0;
            KIND_PAUSE:   paused_in[hidx] = 1'b1;
            KIND_UNPAUSE: paused_in[hidx] = 1'b0;
            default:      ;
         endcase
      end

      // The newest reportable expiry waits in pend until the next one or the
      // end of the scan shows whether it is the last result.
      pend_in     = pend_ff;
      pend_hnd_in = pend_hnd_ff;
      cnt_in      = cnt_ff;
      if (cmd.load) begin
         pend_in = 1'b0;
         cnt_in  = '0;
      end else if (cmd.upd && fire && report) begin
         pend_in     = 1'b1;
         pend_hnd_in = idx_hnd;
         cnt_in      = cnt_ff + CNT_W'(1);
      end else if (cmd.emit && (cmd.sel == RSEL_TICK_END)) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      out_handle_in = out_handle_ff;
      out_fired_in  = out_fired_ff;
      out_status_in = out_status_ff;
      out_paused_in = out_paused_ff;
      out_active_in = out_active_ff;
      out_last_in   = out_last_ff;
      if (out_load) begin
         out_handle_in = '0;
         out_fired_in  = 1'b0;
         out_status_in = STATUS_OK;
         out_paused_in = 1'b0;
         out_active_in = 1'b0;
         out_last_in   = 1'b1;
         if (!cmd.emit) begin
            out_handle_in = pend_hnd_ff;
            out_fired_in  = 1'b1;
            out_last_in   = 1'b0;
         end else begin
            case (cmd.sel)
               RSEL_TICK_END: begin
                  out_handle_in = pend_ff ? pend_hnd_ff : '0;
                  out_fired_in  = pend_ff;
               end
               RSEL_SET_OK: begin
                  out_handle_in = idx_hnd;
               end
               RSEL_SET_REJ: begin
                  out_status_in = STATUS_REJECTED;
               end
               RSEL_HANDLE: begin
                  out_handle_in = handle_ff;
                  if ((kind_ff == KIND_CLEAR) || (kind_ff == KIND_PAUSE) ||
                      (kind_ff == KIND_UNPAUSE) || (kind_ff == KIND_QUERY)) begin
                     out_status_in = found ? STATUS_OK : STATUS_BAD_HANDLE;
                  end
                  if (kind_ff == KIND_QUERY) begin
                     out_paused_in = found && paused_ff[hidx];
                     out_active_in = found && !paused_ff[hidx];
                  end
               end
               default: ;
            endcase
         end
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         paused_ff    <= '0;
         loop_ff      <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         paused_ff    <= paused_in;
         loop_ff      <= loop_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      handle_ff     <= handle_in;
      rate_ff       <= rate_in;
      rep_ff        <= rep_in;
      delta_ff      <= delta_in;
      r_ff          <= r_in;
      pend_hnd_ff   <= pend_hnd_in;
      out_handle_ff <= out_handle_in;
      out_fired_ff  <= out_fired_in;
      out_status_ff <= out_status_in;
      out_paused_ff <= out_paused_in;
      out_active_ff <= out_active_in;
      out_last_ff   <= out_last_in;
   end

   assign stat.kind      = kind_ff;
   assign stat.idx_last  = (idx_ff == IDX_W'(NUM_TIMERS - 1));
   assign stat.slot_live = used_ff[idx_ff] && !paused_ff[idx_ff];
   assign stat.slot_free = !used_ff[idx_ff];
   assign stat.rate_zero = (rate_ff == '0);
   assign stat.need_out  = need_out;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_handle = out_handle_ff;
   assign rsp_fired         = out_fired_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_is_paused     = out_paused_ff;
   assign rsp_is_active     = out_active_ff;
   assign rsp_last          = out_last_ff;

endmodule

// File: rtl/multi_timer_table.sv
// Table of NUM_TIMERS periodic or one-shot timers, driven one command item at a
// time. A tick item walks every slot in order through a single read port of the
// period and remaining-count RAMs: a running slot is read, has the elapsed time
// subtracted and is written back, and a free or paused slot is skipped; the scan
// can wait while the result channel is stalled. A set item scans for the lowest
// free slot, or through the whole table when it is full. One item is worked on
// at a time and req_stall is high while it is in progress; results leave through
// an output register, so the next item can be accepted while the final result of
// the previous one still waits on rsp_stall. A tick reports up to sixteen
// expiries in slot order, the last one marked with rsp_last; every expired slot
// is updated even when it is not reported. Handles are slot numbers plus one,
// and handle 0 is never valid.
module multi_timer_table #(
   parameter int NUM_TIMERS = 16,
   parameter int TIME_BITS  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mtt_pkg::KIND_W-1:0]   req_kind,
   input  logic [mtt_pkg::HANDLE_W-1:0] req_handle,
   input  logic [mtt_pkg::FIELD_W-1:0]  req_rate,
   input  logic                         req_repeat_req,
   input  logic [mtt_pkg::FIELD_W-1:0]  req_delta,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mtt_pkg::HANDLE_W-1:0] rsp_result_handle,
   output logic                         rsp_fired,
   output logic [mtt_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_is_paused,
   output logic                         rsp_is_active,
   output logic                         rsp_last
);

   import mtt_pkg::*;

   // The controller sequences the slot scan; the datapath holds the slot
   // flags, both RAMs, the tick arithmetic and the output register.
   cmd_type  cmd;
   stat_type stat;

   mtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mtt_datapath #(
      .NUM_TIMERS (NUM_TIMERS),
      .TIME_BITS  (TIME_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_kind),
      .req_handle        (req_handle),
      .req_rate          (req_rate),
      .req_repeat_req    (req_repeat_req),
      .req_delta         (req_delta),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_result_handle (rsp_result_handle),
      .rsp_fired         (rsp_fired),
      .rsp_status        (rsp_status),
      .rsp_is_paused     (rsp_is_paused),
      .rsp_is_active     (rsp_is_active),
      .rsp_last          (rsp_last)
   );

endmodule
